// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the associative memory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define HDCAM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HDCAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hdcam_pkg.sv =====
// Shared constants, types and helper functions of the associative memory.
package hdcam_pkg;

  localparam int VECTOR_BITS = 1024;
  localparam int ENTRIES     = 64;
  localparam int WORD_BITS   = 32;
  localparam int VEC_WORDS   = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;

  localparam int SLOT_W      = $clog2(ENTRIES);
  localparam int WORD_IDX_W  = (VEC_WORDS > 1) ? $clog2(VEC_WORDS) : 1;
  localparam int BIT_CNT_W   = $clog2(VECTOR_BITS);
  localparam int WORD_LO_W   = $clog2(WORD_BITS);
  localparam int HAM_W       = $clog2(VECTOR_BITS + 1);
  localparam int POP_W       = $clog2(WORD_BITS + 1);
  localparam int CMP_W       = (HAM_W + 2 > 12) ? HAM_W + 2 : 12;
  localparam int VMEM_DEPTH  = 2 ** (SLOT_W + WORD_IDX_W);

  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 6;
  localparam int SCORE_W     = 12;
  localparam int KEY_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [KEY_W-1:0] ZERO_SEED = 32'h5241_4641;

  localparam logic signed [SCORE_W-1:0] EXACT_RESET  = 12'sd1014;
  localparam logic signed [SCORE_W-1:0] REPORT_RESET = 12'sd103;

  localparam logic [CFG_IDX_W-1:0] CFG_EXACT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT = 1'b1;

  localparam logic KIND_LEARN = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_MATCH     = 3'd2,
    ST_EXACT     = 3'd3,
    ST_NOMATCH   = 3'd4
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // latch request, seed generator, rewind slot index
    logic gen_step;   // one generator step, one vector bit
    logic idx_inc;
    logic ham_clr;    // start a slot compare
    logic ham_add;    // accumulate one word
    logic eval;       // threshold check of a finished slot
    logic commit;     // learn: store key, set valid, bump write pointer
    logic emit_dup;
    logic emit_ins;
    logic emit_final; // last query result (pending hit or no-match)
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic kind;
    logic key_match;
    logic idx_last;
    logic slot_valid;
    logic gen_last;
    logic word_last;
    logic hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

  function automatic logic [KEY_W-1:0] xorshift32(input logic [KEY_W-1:0] r);
    logic [KEY_W-1:0] t;
    t = r ^ (r << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + POP_W'(x[i]);
    end
    return n;
  endfunction

  function automatic logic signed [SCORE_W-1:0] sat_score(
      input logic signed [CMP_W-1:0] d);
    logic signed [SCORE_W-1:0] s;
    if (d > $signed(CMP_W'(2047))) begin
      s = 12'sh7FF;
    end else if (d < -$signed(CMP_W'(2048))) begin
      s = -12'sh800;
    end else begin
      s = SCORE_W'(d);
    end
    return s;
  endfunction

endpackage

// ===== rtl/hdcam_if.sv =====
// Request and response channel interfaces of the associative memory.
interface hdcam_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [hdcam_pkg::KEY_W-1:0] key_hash;

  modport source (output valid, kind, key_hash, input ready);
  modport sink   (input valid, kind, key_hash, output ready);
endinterface

interface hdcam_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [hdcam_pkg::STATUS_W-1:0]      status;
  logic [hdcam_pkg::SLOT_OUT_W-1:0]    slot;
  logic signed [hdcam_pkg::SCORE_W-1:0] score;
  logic                                last;

  modport source (output valid, status, slot, score, last, input ready);
  modport sink   (input valid, status, slot, score, last, output ready);
endinterface

// ===== rtl/hdcam_ctrl.sv =====
// Sequencer of the associative memory: learn scan/write and query compare.
`include "assert_macros.svh"

module hdcam_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output hdcam_pkg::cmd_t   cmd,
  input  hdcam_pkg::sts_t   sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_LREAD, S_LCMP, S_LDUP, S_LGEN, S_LINS,
    S_QGEN, S_QSLOT, S_QRD, S_QADD, S_QEVAL, S_QDONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_QGEN;
        end
      end
      S_LREAD: state_next = S_LCMP;
      S_LCMP: begin
        if (sts.key_match) begin
          state_next = S_LDUP;
        end else if (sts.idx_last) begin
          state_next = S_LGEN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_LREAD;
        end
      end
      S_LDUP: begin
        if (sts.out_free) begin
          cmd.emit_dup = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_LGEN: begin
        cmd.gen_step = 1'b1;
        if (sts.gen_last) state_next = S_LINS;
      end
      S_LINS: begin
        if (sts.out_free) begin
          cmd.emit_ins = 1'b1;
          cmd.commit   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_QGEN: begin
        // learn items only pass through here to be dispatched to the key scan
        if (sts.kind == hdcam_pkg::KIND_LEARN) begin
          state_next = S_LREAD;
        end else begin
          cmd.gen_step = 1'b1;
          if (sts.gen_last) state_next = S_QSLOT;
        end
      end
      S_QSLOT: begin
        if (sts.slot_valid) begin
          cmd.ham_clr = 1'b1;
          state_next  = S_QRD;
        end else if (sts.idx_last) begin
          state_next = S_QDONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_QRD: state_next = S_QADD;
      S_QADD: begin
        cmd.ham_add = 1'b1;
        state_next  = sts.word_last ? S_QEVAL : S_QRD;
      end
      S_QEVAL: begin
        // a new hit pushes the held one out, which needs a free output
        if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
          cmd.eval = 1'b1;
          if (sts.idx_last) begin
            state_next = S_QDONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_QSLOT;
          end
        end
      end
      S_QDONE: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `HDCAM_ASSERT(a_emit_free, clk, rst, (cmd.emit_dup || cmd.emit_ins || cmd.emit_final || (cmd.eval && sts.hit && sts.pend_valid)) |-> sts.out_free, "result emitted into a full output register")
  `HDCAM_ASSERT(a_commit_learn, clk, rst, cmd.commit |-> (sts.kind == hdcam_pkg::KIND_LEARN), "commit during a query")
  `HDCAM_ASSERT(a_accept_busy, clk, rst, (in_valid && in_ready) |=> !in_ready, "request accepted without leaving idle")
  `HDCAM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE), "not idle after reset")

endmodule

// ===== rtl/hdcam_datapath.sv =====
// Datapath: vector generator, stores, popcount accumulator and result register.
module hdcam_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  hdcam_pkg::cmd_t                         cmd,
  output hdcam_pkg::sts_t                         sts,
  input  logic                                    req_kind,
  input  logic [hdcam_pkg::KEY_W-1:0]             req_key,
  input  logic                                    cfg_we,
  input  logic [hdcam_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hdcam_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [hdcam_pkg::STATUS_W-1:0]          out_status,
  output logic [hdcam_pkg::SLOT_OUT_W-1:0]        out_slot,
  output logic signed [hdcam_pkg::SCORE_W-1:0]    out_score,
  output logic                                    out_last
);

  localparam int AW = hdcam_pkg::SLOT_W + hdcam_pkg::WORD_IDX_W;

  logic [hdcam_pkg::WORD_BITS-1:0] vec_mem [hdcam_pkg::VMEM_DEPTH];
  logic [hdcam_pkg::KEY_W-1:0]     key_mem [hdcam_pkg::ENTRIES];
  logic [hdcam_pkg::WORD_BITS-1:0] q_buf   [2 ** hdcam_pkg::WORD_IDX_W];

  logic                                kind_q;
  logic [hdcam_pkg::KEY_W-1:0]         key_q;
  logic [hdcam_pkg::KEY_W-1:0]         rng;
  logic [hdcam_pkg::BIT_CNT_W-1:0]     bit_cnt;
  logic [hdcam_pkg::WORD_BITS-1:0]     word_buf;
  logic [hdcam_pkg::SLOT_W-1:0]        idx;
  logic [hdcam_pkg::WORD_IDX_W-1:0]    word;
  logic [hdcam_pkg::HAM_W-1:0]         ham;
  logic [hdcam_pkg::KEY_W-1:0]         key_rd;
  logic [hdcam_pkg::WORD_BITS-1:0]     vec_rd;
  logic [hdcam_pkg::WORD_BITS-1:0]     q_rd;
  logic [hdcam_pkg::ENTRIES-1:0]       valid;
  logic [hdcam_pkg::SLOT_W-1:0]        wp;
  logic signed [hdcam_pkg::SCORE_W-1:0] thr_exact, thr_report;

  logic                                pend_valid;
  hdcam_pkg::status_t                  pend_status;
  logic [hdcam_pkg::SLOT_W-1:0]        pend_slot;
  logic signed [hdcam_pkg::SCORE_W-1:0] pend_score;

  // generator
  logic [hdcam_pkg::KEY_W-1:0]         rng_next;
  logic [hdcam_pkg::WORD_LO_W-1:0]     bit_lo;
  logic [hdcam_pkg::WORD_BITS-1:0]     word_cur;
  logic [hdcam_pkg::WORD_IDX_W-1:0]    gen_word;
  logic                                gen_last, gen_wr;

  assign rng_next = hdcam_pkg::xorshift32(rng);
  assign bit_lo   = bit_cnt[hdcam_pkg::WORD_LO_W-1:0];
  assign gen_word = hdcam_pkg::WORD_IDX_W'(bit_cnt >> hdcam_pkg::WORD_LO_W);
  assign gen_last = (bit_cnt == hdcam_pkg::BIT_CNT_W'(hdcam_pkg::VECTOR_BITS - 1));
  assign word_cur = ((bit_lo == '0) ? '0 : word_buf)
                  | (hdcam_pkg::WORD_BITS'(rng_next[0]) << bit_lo);
  assign gen_wr   = cmd.gen_step && ((bit_lo == '1) || gen_last);

  // scoring
  logic signed [hdcam_pkg::CMP_W-1:0] dot, thr_e, thr_r;
  logic hit_exact, hit;

  assign dot = $signed(hdcam_pkg::CMP_W'(hdcam_pkg::VECTOR_BITS))
             - $signed(hdcam_pkg::CMP_W'({ham, 1'b0}));
  assign thr_e     = hdcam_pkg::CMP_W'(thr_exact);
  assign thr_r     = hdcam_pkg::CMP_W'(thr_report);
  assign hit_exact = (dot >= thr_e);
  assign hit       = hit_exact || (dot >= thr_r);

  logic out_free, push_pend;
  assign out_free  = !out_valid || out_ready;
  assign push_pend = cmd.eval && hit && pend_valid;

  always_comb begin
    sts.kind       = kind_q;
    sts.key_match  = valid[idx] && (key_rd == key_q);
    sts.idx_last   = (idx == hdcam_pkg::SLOT_W'(hdcam_pkg::ENTRIES - 1));
    sts.slot_valid = valid[idx];
    sts.gen_last   = gen_last;
    sts.word_last  = (word == hdcam_pkg::WORD_IDX_W'(hdcam_pkg::VEC_WORDS - 1));
    sts.hit        = hit;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

  // memories, reads registered
  always_ff @(posedge clk) begin
    if (gen_wr && kind_q == hdcam_pkg::KIND_LEARN) begin
      vec_mem[AW'({wp, gen_word})] <= word_cur;
    end
    if (gen_wr && kind_q == hdcam_pkg::KIND_QUERY) begin
      q_buf[gen_word] <= word_cur;
    end
    if (cmd.commit) begin
      key_mem[wp] <= key_q;
    end
    key_rd <= key_mem[idx];
    vec_rd <= vec_mem[AW'({idx, word})];
    q_rd   <= q_buf[word];
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= req_kind;
      key_q   <= req_key;
      rng     <= (req_key != '0) ? req_key : hdcam_pkg::ZERO_SEED;
      bit_cnt <= '0;
    end else if (cmd.gen_step) begin
      rng      <= rng_next;
      bit_cnt  <= bit_cnt + 1'b1;
      word_buf <= word_cur;
    end
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.ham_clr) begin
      ham  <= '0;
      word <= '0;
    end else if (cmd.ham_add) begin
      ham  <= ham + hdcam_pkg::HAM_W'(hdcam_pkg::popcount(vec_rd ^ q_rd));
      word <= word + 1'b1;
    end
    if (cmd.eval && hit) begin
      pend_status <= hit_exact ? hdcam_pkg::ST_EXACT : hdcam_pkg::ST_MATCH;
      pend_slot   <= idx;
      pend_score  <= hdcam_pkg::sat_score(dot);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      wp         <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      thr_exact  <= hdcam_pkg::EXACT_RESET;
      thr_report <= hdcam_pkg::REPORT_RESET;
    end else begin
      if (cfg_we && cfg_index == hdcam_pkg::CFG_EXACT) thr_exact <= cfg_data;
      if (cfg_we && cfg_index == hdcam_pkg::CFG_REPORT) thr_report <= cfg_data;
      if (cmd.commit) begin
        valid[wp] <= 1'b1;
        wp <= (wp == hdcam_pkg::SLOT_W'(hdcam_pkg::ENTRIES - 1)) ? '0 : wp + 1'b1;
      end
      if (cmd.load) begin
        pend_valid <= 1'b0;
      end else if (cmd.eval && hit) begin
        pend_valid <= 1'b1;
      end
      if (cmd.emit_dup || cmd.emit_ins || cmd.emit_final || push_pend) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit_dup) begin
      out_status <= hdcam_pkg::ST_DUPLICATE;
      out_slot   <= hdcam_pkg::SLOT_OUT_W'(idx);
      out_score  <= '0;
      out_last   <= 1'b1;
    end else if (cmd.emit_ins) begin
      out_status <= hdcam_pkg::ST_INSERTED;
      out_slot   <= hdcam_pkg::SLOT_OUT_W'(wp);
      out_score  <= '0;
      out_last   <= 1'b1;
    end else if (push_pend || (cmd.emit_final && pend_valid)) begin
      out_status <= pend_status;
      out_slot   <= hdcam_pkg::SLOT_OUT_W'(pend_slot);
      out_score  <= pend_score;
      out_last   <= cmd.emit_final;
    end else if (cmd.emit_final) begin
      out_status <= hdcam_pkg::ST_NOMATCH;
      out_slot   <= '0;
      out_score  <= '0;
      out_last   <= 1'b1;
    end
  end

endmodule

// ===== rtl/hdc_associative_memory_unit.sv =====
// Top level of the hyperdimensional bipolar associative memory.
// Usage:
//  - req channel carries kind (0 learn, 1 query) and a 32-bit key hash; the
//    hash seeds an xorshift32 generator that builds the key's 1024-bit
//    bipolar vector one bit per cycle.
//  - rsp channel carries status, slot, score and last; last marks the final
//    result of a request. A learn gives one result; a query gives one per
//    reported slot in ascending order, or a single no-match result.
//  - cfg port writes exact_threshold (index 0) and report_threshold (1);
//    write only while the block is idle.
// Sequence (one request at a time):
//  - learn: a read then a compare step per slot of the key scan, then the
//    generator over all 1024 bits; a duplicate returns at its scan position.
//  - query: the generator, then per stored slot 32 word reads, each a read
//    then popcount-accumulate step, and a threshold check; empty slots are
//    skipped. The single-port vector store sets this word-serial order.
// Reset clears the valid bits and write pointer and loads the default
// thresholds at once; there is no clearing pass. A stalled receiver holds
// the result register, and the sequencer waits only when it must place
// another result; a new request is taken while the last result still waits.
module hdc_associative_memory_unit (
  input  logic                                clk,
  input  logic                                rst,
  hdcam_req_if.sink                           req,
  hdcam_rsp_if.source                         rsp,
  input  logic                                cfg_we,
  input  logic [hdcam_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdcam_pkg::CFG_DATA_W-1:0]    cfg_data
);

  hdcam_pkg::cmd_t cmd;
  hdcam_pkg::sts_t sts;

  // sequencer: issues one command set per cycle
  hdcam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // stores, generator, popcount and the result register
  hdcam_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_kind   (req.kind),
    .req_key    (req.key_hash),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_slot   (rsp.slot),
    .out_score  (rsp.score),
    .out_last   (rsp.last)
  );

endmodule
